@@ src/tmpc_pkg.sv @@
package tmpc_pkg;

  // Input transaction fields, first member in the most significant bits.
  typedef struct packed {
    logic        op;
    logic [13:0] tile_index;
    logic [15:0] tile_value;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
  } in_t;

  // Result transaction fields, one flag per probe point.
  typedef struct packed {
    logic top_left;
    logic top_center;
    logic top_right;
    logic center_left;
    logic center_right;
    logic bottom_left;
    logic bottom_center;
    logic bottom_right;
  } out_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int NUM_PROBES  = 8;
  localparam int PROBE_SEL_W = 3;

  // A probe coordinate is at most 16 + 12 bits summed, so 17 bits wide.
  localparam int DIVIDEND_W    = 17;
  localparam int DIV_BITS_STEP = 4;
  localparam int DIV_CYCLES    = (DIVIDEND_W + DIV_BITS_STEP - 1) / DIV_BITS_STEP;
  localparam int DIV_W         = DIV_CYCLES * DIV_BITS_STEP;
  localparam int DIV_CNT_W     = 3;

  // Command and status bundle from the controller to the datapath.
  typedef struct packed {
    logic                   capture;
    logic                   ram_write;
    logic                   div_step;
    logic                   probe_issue;
    logic [PROBE_SEL_W-1:0] probe_sel;
    logic                   load_out;
  } cmd_t;

endpackage

@@ src/tmpc_ram.sv @@
module tmpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/tmpc_ctrl.sv @@
module tmpc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output tmpc_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_LAND   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  localparam logic [tmpc_pkg::DIV_CNT_W-1:0] DIV_LAST =
    tmpc_pkg::DIV_CNT_W'(tmpc_pkg::DIV_CYCLES - 1);
  localparam logic [tmpc_pkg::PROBE_SEL_W-1:0] PROBE_LAST =
    tmpc_pkg::PROBE_SEL_W'(tmpc_pkg::NUM_PROBES - 1);

  logic [2:0] state_r, state_nxt;
  logic [tmpc_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [tmpc_pkg::PROBE_SEL_W-1:0] probe_cnt_r, probe_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    probe_cnt_nxt = probe_cnt_r;
    cmd           = '0;
    cmd.probe_sel = probe_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          div_cnt_nxt = '0;
          state_nxt   = (in_op == tmpc_pkg::OP_QUERY) ? S_DIV : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.ram_write = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          probe_cnt_nxt = '0;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe_issue = 1'b1;
        probe_cnt_nxt   = probe_cnt_r + 1'b1;
        if (probe_cnt_r == PROBE_LAST) begin
          state_nxt = S_LAND;
        end
      end
      S_LAND: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      probe_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      probe_cnt_r <= probe_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_WRITE) || (state_r == S_DIV))
    else $error("accepted transaction did not start work");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_div_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (div_cnt_r == DIV_LAST) |=> (state_r == S_PROBE) && (probe_cnt_r == '0))
    else $error("probe sweep did not follow division");

  a_land_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAND) |-> $past(state_r == S_PROBE && probe_cnt_r == PROBE_LAST))
    else $error("landing cycle without final probe issue");

endmodule

@@ src/tmpc_dp.sv @@
module tmpc_dp #(
  parameter int DEPTH        = 16384,
  parameter int TILE_ID_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tmpc_pkg::cmd_t cmd,
  input  tmpc_pkg::in_t  in_data,
  input  logic [7:0]     tile_size,
  input  logic [7:0]     map_columns,
  input  logic [7:0]     map_rows,
  output tmpc_pkg::out_t out_data
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIW = (AW > 14) ? AW : 14;
  localparam int RIW = (AW > 16) ? AW : 16;
  localparam int VW  = (TILE_ID_BITS > 16) ? TILE_ID_BITS : 16;
  localparam int DW  = tmpc_pkg::DIV_W;
  localparam int NL  = 3;

  // Probe j uses x lane PX[j] and y lane PY[j]: lane 0 edge, 1 center, 2 far edge.
  localparam logic [1:0] PX [tmpc_pkg::NUM_PROBES] =
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] PY [tmpc_pkg::NUM_PROBES] =
    '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};

  logic [13:0]             wr_index_r;
  logic [15:0]             wr_value_r;
  logic [7:0]              xrem_r [NL];
  logic [7:0]              yrem_r [NL];
  logic [DW-1:0]           xsh_r [NL];
  logic [DW-1:0]           ysh_r [NL];
  logic [7:0]              xrem_nxt [NL];
  logic [7:0]              yrem_nxt [NL];
  logic [DW-1:0]           xsh_nxt [NL];
  logic [DW-1:0]           ysh_nxt [NL];
  logic [tmpc_pkg::DIVIDEND_W-1:0] xd [NL];
  logic [tmpc_pkg::DIVIDEND_W-1:0] yd [NL];
  logic [tmpc_pkg::NUM_PROBES-1:0] flags_r;
  logic                    issue_vld_r;
  logic                    issue_ok_r;
  logic [tmpc_pkg::PROBE_SEL_W-1:0] issue_sel_r;
  tmpc_pkg::out_t          out_r;

  logic [DW-1:0]           xq, yq;
  logic                    in_range;
  logic [15:0]             idx;
  logic [RIW-1:0]          rd_idx;
  logic [WIW-1:0]          wr_idx;
  logic [VW-1:0]           wr_val;
  logic                    wr_ok;
  logic [TILE_ID_BITS-1:0] rd_data;

  // Probe coordinates, formed without wrap.
  always_comb begin
    xd[0] = {1'b0, in_data.rect_x};
    xd[1] = {1'b0, in_data.rect_x} + 17'(in_data.rect_w[11:1]);
    xd[2] = {1'b0, in_data.rect_x} + 17'(in_data.rect_w);
    yd[0] = {1'b0, in_data.rect_y};
    yd[1] = {1'b0, in_data.rect_y} + 17'(in_data.rect_h[11:1]);
    yd[2] = {1'b0, in_data.rect_y} + 17'(in_data.rect_h);
  end

  // Restoring division, several quotient bits per step in each of six lanes.
  always_comb begin
    logic [8:0] t;
    logic [7:0] r;
    logic [DW-1:0] s;
    for (int l = 0; l < NL; l++) begin
      r = xrem_r[l];
      s = xsh_r[l];
      for (int k = 0; k < tmpc_pkg::DIV_BITS_STEP; k++) begin
        t = {r, s[DW-1]};
        s = {s[DW-2:0], 1'b0};
        r = t[7:0];
        if (t >= {1'b0, tile_size}) begin
          r    = 8'(t - {1'b0, tile_size});
          s[0] = 1'b1;
        end
      end
      xrem_nxt[l] = r;
      xsh_nxt[l]  = s;
      r = yrem_r[l];
      s = ysh_r[l];
      for (int k = 0; k < tmpc_pkg::DIV_BITS_STEP; k++) begin
        t = {r, s[DW-1]};
        s = {s[DW-2:0], 1'b0};
        r = t[7:0];
        if (t >= {1'b0, tile_size}) begin
          r    = 8'(t - {1'b0, tile_size});
          s[0] = 1'b1;
        end
      end
      yrem_nxt[l] = r;
      ysh_nxt[l]  = s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wr_index_r <= in_data.tile_index;
      wr_value_r <= in_data.tile_value;
      for (int l = 0; l < NL; l++) begin
        xrem_r[l] <= '0;
        yrem_r[l] <= '0;
        xsh_r[l]  <= DW'(xd[l]);
        ysh_r[l]  <= DW'(yd[l]);
      end
    end else if (cmd.div_step) begin
      for (int l = 0; l < NL; l++) begin
        xrem_r[l] <= xrem_nxt[l];
        yrem_r[l] <= yrem_nxt[l];
        xsh_r[l]  <= xsh_nxt[l];
        ysh_r[l]  <= ysh_nxt[l];
      end
    end
  end

  // Tile address of the selected probe; out-of-map and zero tile size read empty.
  always_comb begin
    xq       = xsh_r[PX[cmd.probe_sel]];
    yq       = ysh_r[PY[cmd.probe_sel]];
    idx      = {8'b0, yq[7:0]} * {8'b0, map_columns} + {8'b0, xq[7:0]};
    in_range = (tile_size != 8'd0) && (xq < DW'(map_columns)) && (yq < DW'(map_rows))
               && (32'(idx) < DEPTH);
    rd_idx   = RIW'(idx);
  end

  always_comb begin
    wr_idx = WIW'(wr_index_r);
    wr_val = VW'(wr_value_r);
    wr_ok  = cmd.ram_write && (32'(wr_index_r) < DEPTH);
  end

  tmpc_ram #(
    .WIDTH (TILE_ID_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_val[TILE_ID_BITS-1:0]),
    .rd_en   (cmd.probe_issue),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_vld_r <= 1'b0;
    end else begin
      issue_vld_r <= cmd.probe_issue;
    end
    issue_ok_r  <= in_range;
    issue_sel_r <= cmd.probe_sel;
    if (cmd.capture) begin
      flags_r <= '0;
    end else if (issue_vld_r) begin
      flags_r[issue_sel_r] <= issue_ok_r && (rd_data != '0);
    end
    if (cmd.load_out) begin
      out_r.top_left      <= flags_r[0];
      out_r.top_center    <= flags_r[1];
      out_r.top_right     <= flags_r[2];
      out_r.center_left   <= flags_r[3];
      out_r.center_right  <= flags_r[4];
      out_r.bottom_left   <= flags_r[5];
      out_r.bottom_center <= flags_r[6];
      out_r.bottom_right  <= flags_r[7];
    end
  end

  assign out_data = out_r;

endmodule

@@ src/tile_map_probe_collision.sv @@
// Tile map collision probe. Write transactions (op 0) store one tile id at a
// linear index; query transactions (op 1) test eight probe points of a
// rectangle (corners, top/bottom centers, left/right centers) and return one
// flag per probe, set when the tile under it holds a nonzero id. Probes past
// map_columns or map_rows, past the store depth, or with tile_size zero read
// empty. Every transaction returns exactly one result; writes return all
// zeros. A write passes through capture, the RAM write and the load of the
// result register; a query passes through capture, the six-lane divider (4
// quotient bits per lane per cycle), 8 tile reads through the single read
// port of the tile RAM, a landing state and the load of the result register,
// which waits while a held result is stalled. The input stalls while a
// transaction is in work; a finished result waits in its own register, so
// the next transaction is taken while it is held. The tile store is not
// cleared by reset: read only entries that were written.
module tile_map_probe_collision #(
  parameter int MAX_COLUMNS  = 128,
  parameter int MAX_ROWS     = 128,
  parameter int TILE_ID_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  // input channel
  input  logic           in_valid,
  output logic           in_stall,
  input  tmpc_pkg::in_t  in_data,
  // result channel
  output logic           out_valid,
  input  logic           out_stall,
  output tmpc_pkg::out_t out_data,
  // configuration port
  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [3:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;

  // Register indexes, at byte address 4 * index.
  localparam logic [1:0] REG_TILE_SIZE   = 2'd0;
  localparam logic [1:0] REG_MAP_COLUMNS = 2'd1;
  localparam logic [1:0] REG_MAP_ROWS    = 2'd2;

  logic [7:0] tile_size_r, tile_size_nxt;
  logic [7:0] map_columns_r, map_columns_nxt;
  logic [7:0] map_rows_r, map_rows_nxt;
  logic       cfg_wr;
  tmpc_pkg::cmd_t cmd;

  // Write at the access phase; no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    tile_size_nxt   = tile_size_r;
    map_columns_nxt = map_columns_r;
    map_rows_nxt    = map_rows_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_TILE_SIZE:   tile_size_nxt   = cfg_pwdata[7:0];
        REG_MAP_COLUMNS: map_columns_nxt = cfg_pwdata[7:0];
        REG_MAP_ROWS:    map_rows_nxt    = cfg_pwdata[7:0];
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r   <= 8'd16;
      map_columns_r <= 8'd128;
      map_rows_r    <= 8'd128;
    end else begin
      tile_size_r   <= tile_size_nxt;
      map_columns_r <= map_columns_nxt;
      map_rows_r    <= map_rows_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TILE_SIZE:   cfg_prdata = {24'b0, tile_size_r};
      REG_MAP_COLUMNS: cfg_prdata = {24'b0, map_columns_r};
      REG_MAP_ROWS:    cfg_prdata = {24'b0, map_rows_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Sequencer: capture, divide, sweep probes, hand result to output register.
  tmpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Divider lanes, probe addressing, tile RAM and result register.
  tmpc_dp #(
    .DEPTH        (DEPTH),
    .TILE_ID_BITS (TILE_ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .tile_size   (tile_size_r),
    .map_columns (map_columns_r),
    .map_rows    (map_rows_r),
    .out_data    (out_data)
  );

endmodule

@@ verif/tile_map_probe_collision_test.sv @@
module tile_map_probe_collision_test;

  localparam int STORE_DEPTH     = 128 * 128;
  localparam int REG_TILE_SIZE   = 0;
  localparam int REG_MAP_COLUMNS = 1;
  localparam int REG_MAP_ROWS    = 2;
  localparam int ITEM_TARGET     = 1650;
  // From here on the result side stops stalling and the sender stops its idle bursts.
  localparam int CALM_AFTER      = 1400;
  localparam int REPORT_CAP      = 100;
  localparam int DRAIN_CYCLES    = 32;

  // Probe order matches the result struct: column pick (left, center, right)
  // and row pick (top, center, bottom) for each of the eight flags.
  localparam int XSEL [tmpc_pkg::NUM_PROBES] = '{0, 1, 2, 0, 2, 0, 1, 2};
  localparam int YSEL [tmpc_pkg::NUM_PROBES] = '{0, 0, 0, 1, 1, 2, 2, 2};

  // Mirror of the tile map and the registers. Holds the flags every accepted
  // transaction should produce, oldest first.
  class collision_tracker;
    int             tile_size;
    int             map_columns;
    int             map_rows;
    logic [15:0]    tiles [STORE_DEPTH];
    bit             written [STORE_DEPTH];
    tmpc_pkg::out_t pending_flags [$];
    int             writes;
    int             queries;
    int             solids;

    function new();
      tile_size   = 16;
      map_columns = 128;
      map_rows    = 128;
      writes      = 0;
      queries     = 0;
      solids      = 0;
    endfunction

    function void set_reg(int idx, int value);
      case (idx)
        REG_TILE_SIZE:   tile_size   = value & 8'hFF;
        REG_MAP_COLUMNS: map_columns = value & 8'hFF;
        REG_MAP_ROWS:    map_rows    = value & 8'hFF;
        default: ;
      endcase
    endfunction

    // Store index read by probe k, or -1 when that probe reads empty.
    function int probe_tile(tmpc_pkg::in_t t, int k);
      int xs [3];
      int ys [3];
      int col;
      int row;
      int idx;
      xs[0] = int'(t.rect_x);
      xs[1] = int'(t.rect_x) + int'(t.rect_w >> 1);
      xs[2] = int'(t.rect_x) + int'(t.rect_w);
      ys[0] = int'(t.rect_y);
      ys[1] = int'(t.rect_y) + int'(t.rect_h >> 1);
      ys[2] = int'(t.rect_y) + int'(t.rect_h);
      if (tile_size == 0) return -1;
      col = xs[XSEL[k]] / tile_size;
      row = ys[YSEL[k]] / tile_size;
      if (col >= map_columns || row >= map_rows) return -1;
      idx = row * map_columns + col;
      if (idx >= STORE_DEPTH) return -1;
      return idx;
    endfunction

    function void note_transaction(tmpc_pkg::in_t t);
      tmpc_pkg::out_t flags;
      int             idx;
      flags = '0;
      if (t.op == tmpc_pkg::OP_WRITE) begin
        tiles[t.tile_index]   = t.tile_value;
        written[t.tile_index] = 1'b1;
        writes++;
      end else begin
        for (int k = 0; k < tmpc_pkg::NUM_PROBES; k++) begin
          idx = probe_tile(t, k);
          if (idx >= 0 && tiles[idx] != '0) flags[tmpc_pkg::NUM_PROBES-1-k] = 1'b1;
        end
        queries++;
        solids += $countones(flags);
      end
      pending_flags.push_back(flags);
    endfunction

    // Empty string when the result matches the oldest pending flags.
    function string check_flags(tmpc_pkg::out_t got);
      tmpc_pkg::out_t want;
      string          why;
      string          names [tmpc_pkg::NUM_PROBES];
      names = '{"top_left", "top_center", "top_right", "center_left",
                "center_right", "bottom_left", "bottom_center", "bottom_right"};
      why = "";
      if (pending_flags.size() == 0)
        return $sformatf(" result %b with no transaction pending", got);
      want = pending_flags.pop_front();
      for (int k = 0; k < tmpc_pkg::NUM_PROBES; k++) begin
        if (got[tmpc_pkg::NUM_PROBES-1-k] !== want[tmpc_pkg::NUM_PROBES-1-k])
          why = {why, $sformatf(" %s got %b want %b", names[k],
                                got[tmpc_pkg::NUM_PROBES-1-k],
                                want[tmpc_pkg::NUM_PROBES-1-k])};
      end
      return why;
    endfunction
  endclass

  logic           clk         = 1'b0;
  logic           rst_n       = 1'b0;
  logic           in_valid    = 1'b0;
  logic           in_stall;
  tmpc_pkg::in_t  in_data     = '0;
  logic           out_valid;
  logic           out_stall   = 1'b0;
  tmpc_pkg::out_t out_data;
  logic           cfg_psel    = 1'b0;
  logic           cfg_penable = 1'b0;
  logic           cfg_pwrite  = 1'b0;
  logic [3:0]     cfg_paddr   = '0;
  logic [31:0]    cfg_pwdata  = '0;
  logic [31:0]    cfg_prdata;
  logic           cfg_pready;

  collision_tracker tracker = new();

  int mismatches = 0;
  int items_sent = 0;
  int settings   = 0;
  int stall_left = 0;
  bit calm       = 1'b0;

  always #4 clk = ~clk;

  tile_map_probe_collision dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  task automatic report_mismatch(string why);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("mismatch at %0t:%s", $time, why);
  endtask

  // Result side: check every accepted result transaction, then decide the
  // stall for the next edge. Stalls come in random bursts.
  always @(posedge clk) begin : result_side
    string why;
    if (rst_n && out_valid && !out_stall) begin
      why = tracker.check_flags(out_data);
      if (why != "") report_mismatch(why);
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Empty in about 40% of cases so flags come out mixed.
  function automatic logic [15:0] tile_id();
    return ($urandom_range(0, 4) < 2) ? 16'h0000 : 16'($urandom);
  endfunction

  // Offer one transaction and hold it until accepted, then note it and
  // maybe drop valid for a short burst.
  task automatic send_txn(tmpc_pkg::in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    tracker.note_transaction(t);
    items_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_write(int idx, logic [15:0] value);
    tmpc_pkg::in_t t;
    t.op         = tmpc_pkg::OP_WRITE;
    t.tile_index = 14'(idx);
    t.tile_value = value;
    // Query fields are don't-care on a write; keep them moving.
    t.rect_x     = 16'($urandom);
    t.rect_y     = 16'($urandom);
    t.rect_w     = 12'($urandom);
    t.rect_h     = 12'($urandom);
    send_txn(t);
  endtask

  task automatic send_query(int x, int y, int w, int h);
    tmpc_pkg::in_t t;
    int            idx;
    t.op         = tmpc_pkg::OP_QUERY;
    t.tile_index = 14'($urandom);
    t.tile_value = 16'($urandom);
    t.rect_x     = 16'(x);
    t.rect_y     = 16'(y);
    t.rect_w     = 12'(w);
    t.rect_h     = 12'(h);
    // The tile RAM comes up undefined: write every tile this query would
    // read before the query goes in.
    for (int k = 0; k < tmpc_pkg::NUM_PROBES; k++) begin
      idx = tracker.probe_tile(t, k);
      if (idx >= 0 && !tracker.written[idx]) send_write(idx, tile_id());
    end
    send_txn(t);
  endtask

  // Pause the sender until every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_flags.size() != 0) @(posedge clk);
  endtask

  // One APB write, setup then access. The bus is released by the caller so
  // back-to-back writes never drop and raise psel in one step.
  task automatic cfg_write(int idx, int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(4 * idx);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.set_reg(idx, value);
  endtask

  task automatic apply_settings(int ts, int cols, int rows);
    drain();
    cfg_write(REG_TILE_SIZE, ts);
    cfg_write(REG_MAP_COLUMNS, cols);
    cfg_write(REG_MAP_ROWS, rows);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    int ts;
    int cols;
    int rows;
    int span_x;
    int span_y;
    int roll;
    int idx;
    int w;
    int h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings (16 pixel tiles, 128 x 128).
    send_write(0, 16'hFFFF);
    send_write(STORE_DEPTH - 1, 16'h8001);
    send_write(1, 16'h0000);
    send_query(0, 0, 0, 0);               // zero size: all probes on tile 0
    send_query(0, 0, 16, 0);              // right edge lands on the next tile
    send_query(2032, 2032, 15, 15);       // last tile of the map
    send_query(2032, 2032, 16, 16);       // right and bottom probes past the map
    send_query(65535, 65535, 4095, 4095); // widest sums, fully off the map
    send_query(0, 65535, 4095, 0);
    send_write(0, 16'h0000);
    send_query(0, 0, 0, 0);
    send_write(129, 16'h0001);
    send_query(0, 0, 31, 31);
    send_query(8, 8, 17, 17);
    send_query(2047, 0, 0, 2047);

    // Random part: a series of map settings, extremes first.
    for (int p = 0; items_sent < ITEM_TARGET; p++) begin
      case (p)
        0: begin ts = 1;   cols = 1;   rows = 1;   end
        1: begin ts = 255; cols = 255; rows = 255; end // indexes past the store
        2: begin ts = 0;   cols = 20;  rows = 10;  end // every probe empty
        3: begin ts = 9;   cols = 0;   rows = 0;   end // empty map
        4: begin ts = 16;  cols = 128; rows = 128; end
        default: begin
          ts   = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 255) : $urandom_range(1, 32);
          cols = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 128) : $urandom_range(1, 40);
          rows = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 128) : $urandom_range(1, 40);
        end
      endcase
      apply_settings(ts, cols, rows);
      // Aim most rectangles at the map and a little past its edge.
      span_x = cols * ts + 2 * ts + 8;
      span_y = rows * ts + 2 * ts + 8;
      if (span_x > 65535) span_x = 65535;
      if (span_y > 65535) span_y = 65535;
      repeat ((p < 5) ? 60 : 150) begin
        if (items_sent < ITEM_TARGET) begin
          calm = (items_sent >= CALM_AFTER);
          roll = $urandom_range(0, 99);
          if (roll < 30) begin
            if (cols > 0 && rows > 0 && $urandom_range(0, 4) != 0)
              idx = ($urandom_range(0, rows - 1) * cols + $urandom_range(0, cols - 1))
                    % STORE_DEPTH;
            else
              idx = $urandom_range(0, STORE_DEPTH - 1);
            send_write(idx, tile_id());
          end else if (roll < 90) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, 3 * ts + 1);
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, 3 * ts + 1);
            send_query($urandom_range(0, span_x), $urandom_range(0, span_y), w, h);
          end else begin
            send_query($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 4095), $urandom_range(0, 4095));
          end
          if ($urandom_range(0, 99) == 0) drain();
        end
      end
    end

    calm = 1'b1;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d tile writes and %0d rectangle queries over %0d map settings,",
             tracker.writes, tracker.queries, settings + 1);
    $display("with %0d solid probe flags among the query results.", tracker.solids);
    if (mismatches == 0 && tracker.pending_flags.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #32000000;
    $display("FAILURE");
    $finish;
  end

endmodule
